>>> sv/xcbp_pkg.sv
package xcbp_pkg;

  localparam int MAX_PREFIX_RUN_DEF = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] BYTE_FS     = 8'h64;
  localparam logic [7:0] BYTE_GS     = 8'h65;
  localparam logic [7:0] BYTE_ESC    = 8'h0f;
  localparam logic [7:0] BYTE_SYS    = 8'h05;
  localparam logic [7:0] BYTE_UD2    = 8'h0b;
  localparam logic [7:0] BYTE_OPSZ   = 8'h66;
  localparam logic [7:0] BYTE_ADSZ   = 8'h67;
  localparam logic [7:0] BYTE_REPNE  = 8'hf2;
  localparam logic [7:0] BYTE_REP    = 8'hf3;
  localparam logic [7:0] BYTE_REX_LO = 8'h40;
  localparam logic [7:0] BYTE_REX_HI = 8'h4f;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_SYSCALL = 2'd1;
  localparam logic [1:0] KIND_TLS     = 2'd2;

  typedef struct packed {
    logic is_esc;
    logic is_sys;
    logic is_fs;
    logic pfx;
    logic rex;
    logic mem;
    logic esc_op;
  } class_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    class_t     cls;
  } entry_t;

  function automatic logic is_memory_opcode(logic [7:0] v);
    logic r;
    case (v) inside
      8'h01, 8'h03, 8'h09, 8'h0b, 8'h21, 8'h23, 8'h29, 8'h2b,
      8'h31, 8'h33, 8'h39, 8'h3b, 8'h63, 8'h80, 8'h81, 8'h83,
      8'h86, 8'h87, 8'h88, 8'h89, 8'h8a, 8'h8b, 8'h8d, 8'hc6,
      8'hc7, 8'hf6, 8'hf7, 8'hfe, 8'hff: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_escape_opcode(logic [7:0] v);
    logic r;
    case (v) inside
      8'haf, 8'hb0, 8'hb1, 8'hb6, 8'hb7, 8'hbe, 8'hbf, 8'hc0, 8'hc1: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic class_t classify(logic [7:0] v);
    class_t c;
    c.is_esc = (v == BYTE_ESC);
    c.is_sys = (v == BYTE_SYS);
    c.is_fs  = (v == BYTE_FS);
    c.pfx    = (v == BYTE_OPSZ) || (v == BYTE_ADSZ) || (v == BYTE_REPNE) ||
               (v == BYTE_REP);
    c.rex    = (v >= BYTE_REX_LO) && (v <= BYTE_REX_HI);
    c.mem    = is_memory_opcode(v);
    c.esc_op = is_escape_opcode(v);
    return c;
  endfunction

endpackage

>>> sv/xcbp_front.sv
module xcbp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output xcbp_pkg::entry_t  q_entry
);

  logic             f_valid;
  xcbp_pkg::entry_t f_entry;
  logic             accept;

  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = f_valid && !q_full;
  assign q_entry  = f_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_entry.data <= in_byte;
      f_entry.last <= in_last;
      f_entry.cls  <= xcbp_pkg::classify(in_byte);
    end
  end

endmodule

>>> sv/xcbp_fifo.sv
module xcbp_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xcbp_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output xcbp_pkg::entry_t  head
);

  localparam int DEPTH = xcbp_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  xcbp_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;

  assign full  = (fill == (AW+1)'(DEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> sv/xcbp_back.sv
module xcbp_back #(
  parameter int MAX_PREFIX_RUN = xcbp_pkg::MAX_PREFIX_RUN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  xcbp_pkg::entry_t  q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic [1:0]        rewrite_kind,
  output logic              out_last,
  output logic [31:0]       syscall_count,
  output logic [31:0]       tls_count
);

  // window: 64, prefix run, REX, 0F, escape opcode
  localparam int DEPTH   = MAX_PREFIX_RUN + 4;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int RUN_LEN = MAX_PREFIX_RUN + 2;

  typedef enum logic [1:0] {DEC_WAIT, DEC_PLAIN, DEC_FS, DEC_PAIR} dec_t;

  xcbp_pkg::entry_t win [DEPTH];
  xcbp_pkg::entry_t win_next [DEPTH];
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_after;
  logic             pair_pending;
  logic [31:0]      syscall_total;
  logic [31:0]      tls_total;

  logic [DEPTH-1:0]   vld;
  logic [RUN_LEN-1:0] run;
  logic               seg_end;
  logic               fs64;
  logic               wait64;
  dec_t               head_dec;
  logic               emit_req;
  logic [7:0]         emit_byte;
  logic [1:0]         emit_kind;
  logic               fire;
  logic               load;

  function automatic dec_t opc_dec(xcbp_pkg::entry_t op, logic op_vld,
                                   xcbp_pkg::entry_t nx, logic nx_vld);
    dec_t d;
    if (!op_vld) d = DEC_WAIT;
    else if (op.cls.mem) d = DEC_FS;
    else if (!op.cls.is_esc) d = DEC_PLAIN;
    else if (!nx_vld) d = DEC_WAIT;
    else if (nx.cls.esc_op) d = DEC_FS;
    else d = DEC_PLAIN;
    return d;
  endfunction

  always_comb begin
    dec_t pd;
    pd      = DEC_PLAIN;
    seg_end = 1'b0;
    for (int j = 0; j < DEPTH; j++) begin
      vld[j]  = (CNT_W'(j) < cnt);
      seg_end = seg_end | (vld[j] & win[j].last);
    end
    run[0] = 1'b1;
    for (int p = 1; p < RUN_LEN; p++) begin
      run[p] = run[p-1] & vld[p] & win[p].cls.pfx;
    end
    // p is the first byte past the prefix run; at most one p qualifies
    fs64   = 1'b0;
    wait64 = 1'b0;
    for (int p = 1; p < RUN_LEN; p++) begin
      pd = DEC_PLAIN;
      if (run[p-1] && !(vld[p] && win[p].cls.pfx)) begin
        if (!vld[p]) pd = DEC_WAIT;
        else if (win[p].cls.rex) pd = opc_dec(win[p+1], vld[p+1], win[p+2], vld[p+2]);
        else pd = opc_dec(win[p], 1'b1, win[p+1], vld[p+1]);
      end
      fs64   = fs64 | (pd == DEC_FS);
      wait64 = wait64 | (pd == DEC_WAIT);
    end

    if (cnt == '0) head_dec = DEC_WAIT;
    else if (win[0].cls.is_esc) begin
      if (!vld[1]) head_dec = seg_end ? DEC_PLAIN : DEC_WAIT;
      else head_dec = win[1].cls.is_sys ? DEC_PAIR : DEC_PLAIN;
    end
    else if (!win[0].cls.is_fs) head_dec = DEC_PLAIN;
    else if (run[RUN_LEN-1]) head_dec = DEC_PLAIN;
    else if (wait64) head_dec = seg_end ? DEC_PLAIN : DEC_WAIT;
    else if (fs64) head_dec = DEC_FS;
    else head_dec = DEC_PLAIN;
  end

  always_comb begin
    emit_req  = (cnt != '0) && (pair_pending || head_dec != DEC_WAIT);
    emit_byte = win[0].data;
    emit_kind = xcbp_pkg::KIND_NONE;
    if (pair_pending) begin
      emit_byte = xcbp_pkg::BYTE_UD2;
      emit_kind = xcbp_pkg::KIND_SYSCALL;
    end else if (head_dec == DEC_FS) begin
      emit_byte = xcbp_pkg::BYTE_GS;
      emit_kind = xcbp_pkg::KIND_TLS;
    end
  end

  assign fire      = emit_req && (!out_valid || !out_stall);
  assign cnt_after = cnt - CNT_W'(fire);
  // hold back the next segment until the current one has drained
  assign load      = !q_empty && !(seg_end && cnt_after != '0) &&
                     (cnt_after < CNT_W'(DEPTH));
  assign q_pop     = load;

  always_comb begin
    for (int j = 0; j < DEPTH - 1; j++) begin
      win_next[j] = fire ? win[j+1] : win[j];
    end
    win_next[DEPTH-1] = win[DEPTH-1];
    for (int j = 0; j < DEPTH; j++) begin
      if (load && cnt_after == CNT_W'(j)) begin
        win_next[j] = q_head;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DEPTH; j++) begin
      win[j] <= win_next[j];
    end
    if (fire) begin
      out_byte     <= emit_byte;
      rewrite_kind <= emit_kind;
      out_last     <= win[0].last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      pair_pending  <= 1'b0;
      out_valid     <= 1'b0;
      syscall_total <= '0;
      tls_total     <= '0;
    end else begin
      cnt <= cnt_after + CNT_W'(load);
      if (fire) begin
        pair_pending <= pair_pending ? 1'b0 : (head_dec == DEC_PAIR);
        out_valid    <= 1'b1;
        if (emit_kind == xcbp_pkg::KIND_SYSCALL && syscall_total != '1) begin
          syscall_total <= syscall_total + 32'd1;
        end
        if (emit_kind == xcbp_pkg::KIND_TLS && tls_total != '1) begin
          tls_total <= tls_total + 32'd1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign syscall_count = syscall_total;
  assign tls_count     = tls_total;

endmodule

>>> sv/x86_code_byte_patcher.sv
// Streams x86 code bytes through with two rewrites: the 05 of every 0F 05 pair
// in one segment becomes 0B, and an FS prefix (64) becomes GS (65) when legacy
// prefixes, an optional REX byte and a memory-form opcode follow it. One byte
// is taken and one byte is given per cycle when nothing stalls; every input
// byte comes out exactly once. A front register classifies each byte and
// hands it through a four-entry queue to the back end, which keeps a window
// of up to MAX_PREFIX_RUN + 4 bytes and releases its head once its fate is
// known, one result per cycle unless stalled. Bytes behind a possible FS
// pattern wait until the pattern resolves (at most MAX_PREFIX_RUN + 3 bytes
// later) or until the byte flagged in_last arrives, which flushes the window.
// A byte passes the front register, queue, window and output register. The
// saturating totals syscall_count and tls_count include the byte on the port.
module x86_code_byte_patcher #(
  parameter int MAX_PREFIX_RUN = xcbp_pkg::MAX_PREFIX_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  rewrite_kind,
  output logic        out_last,
  output logic [31:0] syscall_count,
  output logic [31:0] tls_count
);

  logic             q_full;
  logic             q_push;
  logic             q_empty;
  logic             q_pop;
  xcbp_pkg::entry_t q_in;
  xcbp_pkg::entry_t q_head;

  xcbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  xcbp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  xcbp_back #(
    .MAX_PREFIX_RUN (MAX_PREFIX_RUN)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .rewrite_kind  (rewrite_kind),
    .out_last      (out_last),
    .syscall_count (syscall_count),
    .tls_count     (tls_count)
  );

endmodule

>>> sv/xcbp_checker.sv
module xcbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic [1:0]  rewrite_kind,
  input logic        out_last,
  input logic [31:0] syscall_count,
  input logic [31:0] tls_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(rewrite_kind) && $stable(out_last))
    else $error("output changed while stalled");

  a_syscall_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && rewrite_kind == xcbp_pkg::KIND_SYSCALL |->
      out_byte == xcbp_pkg::BYTE_UD2 && syscall_count != 32'd0)
    else $error("syscall rewrite without 0B or count");

  a_tls_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && rewrite_kind == xcbp_pkg::KIND_TLS |->
      out_byte == xcbp_pkg::BYTE_GS && tls_count != 32'd0)
    else $error("FS rewrite without 65 or count");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rewrite_kind == xcbp_pkg::KIND_NONE ||
      rewrite_kind == xcbp_pkg::KIND_SYSCALL || rewrite_kind == xcbp_pkg::KIND_TLS)
    else $error("bad rewrite kind");

  a_totals_grow: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> syscall_count >= $past(syscall_count) &&
      tls_count >= $past(tls_count))
    else $error("running total went down");

endmodule

bind x86_code_byte_patcher xcbp_checker u_checker (.*);
